// ===== rtl/gss_pkg.sv =====
// Shared types, widths, register codes and the fitness table of the genetic search step.
// Used by gss_ctrl, gss_dpath and genetic_search_generation_step_top; no dependencies.
package gss_pkg;

	// parameter defaults and limits
	localparam int POP_SIZE_DEF    = 4;
	localparam int GENE_BITS_DEF   = 5;
	localparam int CROSS_POINT_DEF = 2;
	localparam int GENE_BITS_MAX   = 8;

	// field widths
	localparam int FIT_W      = 5;
	localparam int COUNT_W    = 16;
	localparam int ROLL_W     = 7;
	localparam int FLIP_W     = 3;
	localparam int MARGIN_W   = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MUTATION_PERCENT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_GENERATIONS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_GENERATIONS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MARGIN      = 2'd3;

	// register reset values
	localparam logic [ROLL_W-1:0]   MUTATION_PERCENT_RST   = 7'd50;
	localparam logic [COUNT_W-1:0]  SETTLE_GENERATIONS_RST = 16'd2000;
	localparam logic [COUNT_W-1:0]  MAX_GENERATIONS_RST    = 16'd4000;
	localparam logic [MARGIN_W-1:0] SETTLE_MARGIN_RST      = 5'd5;
	localparam logic [FIT_W-1:0]    BEST_EVER_RST          = '1;

	// fitness f(x) = x^3/1000 - 3x/10 + 10, truncating, clamped to 0..31
	localparam int FIT_ENTRIES  = 1 << GENE_BITS_MAX;
	localparam int FIT_CUBE_DIV = 1000;
	localparam int FIT_LIN_MUL  = 3;
	localparam int FIT_LIN_DIV  = 10;
	localparam int FIT_OFFSET   = 10;
	localparam int FIT_MAX      = (1 << FIT_W) - 1;

	typedef logic [FIT_ENTRIES-1:0][FIT_W-1:0] fit_table_t;

	function automatic fit_table_t build_fit_table();
		fit_table_t tab;
		int cube;
		int lin;
		for (int i = 0; i < FIT_ENTRIES; i++) begin
			cube = (i * i * i) / FIT_CUBE_DIV;
			lin  = (FIT_LIN_MUL * i) / FIT_LIN_DIV;
			if (lin > cube + FIT_OFFSET) begin
				tab[i] = '0;
			end else if (cube + FIT_OFFSET - lin > FIT_MAX) begin
				tab[i] = FIT_W'(FIT_MAX);
			end else begin
				tab[i] = FIT_W'(cube + FIT_OFFSET - lin);
			end
		end
		return tab;
	endfunction

	localparam fit_table_t FIT_TAB = build_fit_table();

	// controller to datapath
	typedef struct packed {
		logic accept;      // capture input word and prepare children
		logic ins_first;   // insert first held gene
		logic ins_second;  // insert second child, bump generation count
		logic bump_load;   // count one loaded gene
		logic check;       // run stop tests
		logic finish;      // load result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic func;        // word is a generation step
		logic full;        // population fully loaded
		logic last_load;   // one gene short of full
		logic stopped;     // stop flag set
	} stat_t;

endpackage

// ===== rtl/gss_ctrl.sv =====
// Sequencer of the genetic search step: accept, insert passes, stop test, result hand-off.
// Depends on gss_pkg (cmd_t, stat_t).
module gss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  gss_pkg::stat_t stat,
	output gss_pkg::cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_INS1 = 2'd1;
	localparam logic [1:0] ST_INS2 = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       gen_q;
	logic       gen_d;
	logic       chk_q;
	logic       chk_d;
	logic       m_valid_q;
	logic       slot_free;

	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_valid_q;

	always_comb begin
		state_d = state_q;
		gen_d   = gen_q;
		chk_d   = chk_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (!stat.func && !stat.full) begin
						state_d = ST_INS1;
						gen_d   = 1'b0;
						chk_d   = stat.last_load;
					end else if (stat.func && stat.full && !stat.stopped) begin
						state_d = ST_INS1;
						gen_d   = 1'b1;
						chk_d   = 1'b1;
					end else begin
						// ignored word: report state only
						state_d = ST_FIN;
						gen_d   = 1'b0;
						chk_d   = 1'b0;
					end
				end
			end
			ST_INS1: begin
				cmd.ins_first = 1'b1;
				cmd.bump_load = !gen_q;
				state_d       = gen_q ? ST_INS2 : ST_FIN;
			end
			ST_INS2: begin
				cmd.ins_second = 1'b1;
				state_d        = ST_FIN;
			end
			ST_FIN: begin
				// hold until the result register is free
				if (slot_free) begin
					cmd.finish = 1'b1;
					cmd.check  = chk_q;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			gen_q     <= 1'b0;
			chk_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			gen_q   <= gen_d;
			chk_q   <= chk_d;
			if (cmd.finish) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/gss_dpath.sv =====
// Datapath of the genetic search step: registers, population with fitness, insert unit,
// crossover and mutation, stop tests and result register. Depends on gss_pkg.
module gss_dpath #(
	parameter  int POP_SIZE    = gss_pkg::POP_SIZE_DEF,
	parameter  int GENE_BITS   = gss_pkg::GENE_BITS_DEF,
	parameter  int CROSS_POINT = gss_pkg::CROSS_POINT_DEF,
	localparam int IN_USED     = GENE_BITS + 2 * (gss_pkg::ROLL_W + gss_pkg::FLIP_W),
	localparam int IN_W        = ((IN_USED + 7) / 8) * 8,
	localparam int OUT_USED    = GENE_BITS + gss_pkg::FIT_W + gss_pkg::COUNT_W + 2,
	localparam int OUT_W       = ((OUT_USED + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [IN_W-1:0]                  s_tdata,
	input  logic                             s_tuser,
	output logic [OUT_W-1:0]                 m_tdata,
	input  logic                             cfg_valid,
	input  logic [gss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gss_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  gss_pkg::cmd_t                    cmd,
	output gss_pkg::stat_t                   stat
);

	localparam int FIT_W    = gss_pkg::FIT_W;
	localparam int COUNT_W  = gss_pkg::COUNT_W;
	localparam int ROLL_W   = gss_pkg::ROLL_W;
	localparam int FLIP_W   = gss_pkg::FLIP_W;
	localparam int MARGIN_W = gss_pkg::MARGIN_W;
	localparam int GMAX     = gss_pkg::GENE_BITS_MAX;
	localparam int LC_W     = $clog2(POP_SIZE + 1);

	localparam int RF_LO = GENE_BITS;
	localparam int FF_LO = RF_LO + ROLL_W;
	localparam int RS_LO = FF_LO + FLIP_W;
	localparam int FS_LO = RS_LO + ROLL_W;

	localparam logic [GENE_BITS-1:0] LOW_MASK  = GENE_BITS'((1 << CROSS_POINT) - 1);
	localparam logic [FLIP_W:0]      FLIP_LIM  = (FLIP_W + 1)'(GENE_BITS);
	localparam logic [LC_W-1:0]      LC_FULL   = LC_W'(POP_SIZE);
	localparam logic [LC_W-1:0]      LC_LAST   = LC_W'(POP_SIZE - 1);
	localparam logic [COUNT_W-1:0]   COUNT_TOP = '1;

	// configuration
	logic [ROLL_W-1:0]   mut_pct_q;
	logic [COUNT_W-1:0]  settle_q;
	logic [COUNT_W-1:0]  max_q;
	logic [MARGIN_W-1:0] margin_q;

	// search state
	logic [GENE_BITS-1:0] pop_q [POP_SIZE];
	logic [FIT_W-1:0]     fit_q [POP_SIZE];
	logic [LC_W-1:0]      load_cnt_q;
	logic [COUNT_W-1:0]   gen_cnt_q;
	logic [FIT_W-1:0]     best_ever_q;
	logic                 stop_q;
	logic [GENE_BITS-1:0] c1_q;
	logic [GENE_BITS-1:0] c2_q;
	logic [OUT_W-1:0]     out_q;

	// input fields
	logic [GENE_BITS-1:0] in_gene;
	logic [ROLL_W-1:0]    roll_first;
	logic [FLIP_W-1:0]    flip_first;
	logic [ROLL_W-1:0]    roll_second;
	logic [FLIP_W-1:0]    flip_second;

	// crossover and mutation
	logic [GENE_BITS-1:0] cross_first;
	logic [GENE_BITS-1:0] cross_second;
	logic [GENE_BITS-1:0] mut_first;
	logic [GENE_BITS-1:0] mut_second;

	// insert unit
	logic [GENE_BITS-1:0] ins_gene;
	logic [FIT_W-1:0]     ins_fit;
	logic [POP_SIZE-1:0]  after;
	logic [GENE_BITS-1:0] pop_d [POP_SIZE];
	logic [FIT_W-1:0]     fit_d [POP_SIZE];

	// stop tests and result
	logic [FIT_W-1:0]     best_fit;
	logic [FIT_W-1:0]     best_ever_d;
	logic [FIT_W-1:0]     settle_diff;
	logic                 stop_hit;
	logic                 stop_d;
	logic                 any_loaded;
	logic [GENE_BITS-1:0] out_gene;
	logic [FIT_W-1:0]     out_fit;

	assign in_gene     = s_tdata[0 +: GENE_BITS];
	assign roll_first  = s_tdata[RF_LO +: ROLL_W];
	assign flip_first  = s_tdata[FF_LO +: FLIP_W];
	assign roll_second = s_tdata[RS_LO +: ROLL_W];
	assign flip_second = s_tdata[FS_LO +: FLIP_W];

	assign cross_first  = (pop_q[0] & ~LOW_MASK) | (pop_q[1] & LOW_MASK);
	assign cross_second = (pop_q[1] & ~LOW_MASK) | (pop_q[0] & LOW_MASK);

	always_comb begin
		mut_first  = cross_first;
		mut_second = cross_second;
		if ((roll_first < mut_pct_q) && ({1'b0, flip_first} < FLIP_LIM)) begin
			mut_first = cross_first ^ (GENE_BITS'(1) << flip_first);
		end
		if ((roll_second < mut_pct_q) && ({1'b0, flip_second} < FLIP_LIM)) begin
			mut_second = cross_second ^ (GENE_BITS'(1) << flip_second);
		end
	end

	// stable insert: the new gene lands after every member of equal or lower fitness;
	// slots beyond the fill count count as vacant
	assign ins_gene = cmd.ins_second ? c2_q : c1_q;
	assign ins_fit  = gss_pkg::FIT_TAB[GMAX'(ins_gene)];

	always_comb begin
		for (int i = 0; i < POP_SIZE; i++) begin
			after[i] = (LC_W'(i) >= load_cnt_q) || (fit_q[i] > ins_fit);
		end
		for (int i = 0; i < POP_SIZE; i++) begin
			pop_d[i] = pop_q[i];
			fit_d[i] = fit_q[i];
			if (after[i]) begin
				if (i == 0) begin
					pop_d[i] = ins_gene;
					fit_d[i] = ins_fit;
				end else if (!after[i-1]) begin
					pop_d[i] = ins_gene;
					fit_d[i] = ins_fit;
				end else begin
					pop_d[i] = pop_q[i-1];
					fit_d[i] = fit_q[i-1];
				end
			end
		end
	end

	// stop tests on the updated best
	assign best_fit    = fit_q[0];
	assign best_ever_d = (best_fit < best_ever_q) ? best_fit : best_ever_q;
	assign settle_diff = best_fit - best_ever_d;
	assign stop_hit    = ((settle_diff < margin_q) && (gen_cnt_q > settle_q))
	                     || (gen_cnt_q > max_q);
	assign stop_d      = stop_q || (cmd.check && stop_hit);

	assign any_loaded = (load_cnt_q != '0);
	assign out_gene   = any_loaded ? pop_q[0] : '0;
	assign out_fit    = any_loaded ? fit_q[0] : '0;

	assign stat.func      = s_tuser;
	assign stat.full      = (load_cnt_q == LC_FULL);
	assign stat.last_load = (load_cnt_q == LC_LAST);
	assign stat.stopped   = stop_q;

	assign m_tdata = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mut_pct_q   <= gss_pkg::MUTATION_PERCENT_RST;
			settle_q    <= gss_pkg::SETTLE_GENERATIONS_RST;
			max_q       <= gss_pkg::MAX_GENERATIONS_RST;
			margin_q    <= gss_pkg::SETTLE_MARGIN_RST;
			load_cnt_q  <= '0;
			gen_cnt_q   <= '0;
			best_ever_q <= gss_pkg::BEST_EVER_RST;
			stop_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					gss_pkg::CFG_MUTATION_PERCENT:   mut_pct_q <= cfg_data[ROLL_W-1:0];
					gss_pkg::CFG_SETTLE_GENERATIONS: settle_q  <= cfg_data[COUNT_W-1:0];
					gss_pkg::CFG_MAX_GENERATIONS:    max_q     <= cfg_data[COUNT_W-1:0];
					gss_pkg::CFG_SETTLE_MARGIN:      margin_q  <= cfg_data[MARGIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.bump_load) begin
				load_cnt_q <= load_cnt_q + 1'b1;
			end
			if (cmd.ins_second && (gen_cnt_q != COUNT_TOP)) begin
				gen_cnt_q <= gen_cnt_q + 1'b1;
			end
			if (cmd.check) begin
				best_ever_q <= best_ever_d;
			end
			stop_q <= stop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			// a load word carries its gene through the first insert pass
			c1_q <= s_tuser ? mut_first : in_gene;
			c2_q <= mut_second;
		end
		if (cmd.ins_first || cmd.ins_second) begin
			for (int i = 0; i < POP_SIZE; i++) begin
				pop_q[i] <= pop_d[i];
				fit_q[i] <= fit_d[i];
			end
		end
		if (cmd.finish) begin
			out_q <= OUT_W'({stat.full, stop_d, gen_cnt_q, out_fit, out_gene});
		end
	end

endmodule

// ===== rtl/genetic_search_generation_step_top.sv =====
// Steady-state genetic search step. Load words: accept, one insert pass, result;
// generation words: accept with crossover and mutation, two insert passes, stop test;
// ignored words: accept, result. One word is in flight at a time, set by the single
// shared insert unit. Input is freed once the result is loaded. arst_n clears counts
// and stop flag, presets best-ever fitness and registers; population is unset.
module genetic_search_generation_step_top #(
	parameter  int POP_SIZE    = gss_pkg::POP_SIZE_DEF,
	parameter  int GENE_BITS   = gss_pkg::GENE_BITS_DEF,
	parameter  int CROSS_POINT = gss_pkg::CROSS_POINT_DEF,
	localparam int IN_USED     = GENE_BITS + 2 * (gss_pkg::ROLL_W + gss_pkg::FLIP_W),
	localparam int IN_W        = ((IN_USED + 7) / 8) * 8,
	localparam int OUT_USED    = GENE_BITS + gss_pkg::FIT_W + gss_pkg::COUNT_W + 2,
	localparam int OUT_W       = ((OUT_USED + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// gene, roll_first, flip_first, roll_second, flip_second, zero fill
	input  logic [IN_W-1:0]                s_tdata,
	// func
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// best_gene, best_fitness, generations_done, finished, loaded, zero fill
	output logic [OUT_W-1:0]               m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gss_pkg::CFG_DATA_W-1:0] cfg_data
);

	gss_pkg::cmd_t  cmd;
	gss_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	gss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gss_dpath #(
		.POP_SIZE    (POP_SIZE),
		.GENE_BITS   (GENE_BITS),
		.CROSS_POINT (CROSS_POINT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

`ifndef SYNTHESIS
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat.stopped |=> stat.stopped)
		else $error("stop flag cleared");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |=> stat.full)
		else $error("loaded flag cleared");

	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_second |-> $past(cmd.ins_first))
		else $error("second insert without first");

	a_idle_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(cmd.ins_first || cmd.ins_second || cmd.finish))
		else $error("datapath busy while accepting");
`endif

endmodule
